/* hdl/bpt_pkg.sv */
// Package for the paged vector translator: sizes, location codes, state and status types.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpt_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int SLOTS      = 16;
    localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LOC_W      = SLOT_W + 1;
    localparam int IDX_W      = 26;
    localparam int CNT_W      = 27;
    localparam int VAL_W      = 32;
    localparam int OFF_W      = 16;
    localparam int CFG_W      = 5;
    localparam int MAX_SHIFT  = 16;
    localparam int CAP_W      = BLK_W + MAX_SHIFT + 1;
    localparam int ALU_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [LOC_W-1:0] LOC_STORED = {1'b1, {SLOT_W{1'b0}}};
    localparam logic [LOC_W-1:0] LOC_NONE   = {1'b1, {(SLOT_W-1){1'b0}}, 1'b1};

    typedef enum logic {
        REG_BLOCK_SHIFT  = 1'b0,
        REG_SLOTS_IN_USE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ALU_GE  = 1'b0,
        ALU_SHR = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SPLIT,
        S_BOUND,
        S_LOOK,
        S_FILL
    } seq_state_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BLK_W-1:0] addr;
        logic [LOC_W-1:0] wr_data;
    } tbl_req_t;

endpackage

`default_nettype wire

/* hdl/bpt_alu.sv */
// Shared compare/shift unit: unsigned greater-or-equal or logical right shift.
// Depends on bpt_pkg.
`default_nettype none

module bpt_alu import bpt_pkg::*; (
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  logic [CFG_W-1:0] sh,
    output logic [ALU_W-1:0] res
);

    always_comb
    begin
        unique case (op)
            ALU_GE:  res = {{(ALU_W-1){1'b0}}, (a >= b)};
            ALU_SHR: res = a >> sh;
            default: res = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bpt_block_table.sv */
// Block location table: one-port memory with registered read and a clearing sweep after reset.
// Depends on bpt_pkg.
`default_nettype none

module bpt_block_table import bpt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_req_t         req,
    output logic [LOC_W-1:0] rd_data,
    output logic             ready
);

    logic [LOC_W-1:0] mem [MAX_BLOCKS];
    logic [LOC_W-1:0] rd_data_reg;
    logic [BLK_W-1:0] clear_cnt_reg;
    logic [BLK_W-1:0] clear_cnt_next;
    logic             clearing_reg;
    logic             clearing_next;
    logic [LOC_W-1:0] init_value;

    assign init_value = (32'(clear_cnt_reg) < SLOTS) ? LOC_W'(clear_cnt_reg) : LOC_NONE;

    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        clearing_next  = clearing_reg;
        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == BLK_W'(MAX_BLOCKS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            clearing_reg  <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_cnt_reg] <= init_value;
        end
        else if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.wr_en && !req.rd_en)
        else $error("table accessed during clearing sweep");

    a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> $past(clear_cnt_reg) == BLK_W'(MAX_BLOCKS - 1))
        else $error("clearing sweep ended early");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |-> !req.wr_en)
        else $error("read and write in the same cycle");

endmodule

`default_nettype wire

/* hdl/block_paging_translator_fifo.sv */
// Top level: paged vector translator with round-robin slot replacement; depends on bpt_pkg,
// bpt_alu and bpt_block_table. The sequencer steps the shared compare/shift unit and the table.
// Steps: range check, split, bound check, look-up, fill on a miss; a full push or out-of-range
// access stops at range or bound check; one word at a time, next start taken in the done cycle.
// Reset: a sweep over every entry initializes the block table, busy is high meanwhile.
// Results are strobed by done for one cycle; the receiver cannot stall.
`default_nettype none

module block_paging_translator_fifo import bpt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [IDX_W-1:0]        element_index,
    input  logic signed [VAL_W-1:0] write_value,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic                    done,
    output logic [SLOT_W-1:0]       slot_number,
    output logic [OFF_W-1:0]        slot_offset,
    output logic                    hit,
    output logic                    writeback_valid,
    output logic [BLK_W-1:0]        writeback_block,
    output logic                    fetch_valid,
    output logic                    fresh_block,
    output logic [BLK_W-1:0]        load_block,
    output logic                    store_write,
    output logic signed [VAL_W-1:0] store_value,
    output logic [1:0]              status
);

    seq_state_t       state_reg, state_next;
    logic [CFG_W-1:0] block_shift_reg;
    logic [CFG_W-1:0] slots_reg;
    logic             cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] blk_reg, blk_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [SLOT_W-1:0] victim_reg, victim_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [BLK_W-1:0] owner_reg [SLOTS];
    logic [SLOTS-1:0] owner_valid_reg;
    logic             owner_we;

    logic             done_reg, done_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             hit_reg, hit_next;
    logic             wb_valid_reg, wb_valid_next;
    logic [BLK_W-1:0] wb_block_reg, wb_block_next;
    logic             fetch_reg, fetch_next;
    logic             fresh_reg, fresh_next;
    logic [BLK_W-1:0] load_reg, load_next;
    logic             st_write_reg, st_write_next;
    logic [VAL_W-1:0] st_value_reg, st_value_next;
    status_t          status_reg, status_next;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic [CFG_W-1:0] sh_eff;
    logic [ALU_W-1:0] cap_full, cap;
    logic [SLOT_W:0]  slots_eff;
    logic [SLOT_W-1:0] look_victim;
    logic [SLOT_W-1:0] fill_ptr;
    logic [OFF_W-1:0] off_mask;

    tbl_req_t         tbl_req;
    logic [LOC_W-1:0] tbl_rd_data;
    logic             tbl_ready;

    bpt_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sh  (sh_eff),
        .res (alu_res)
    );

    bpt_block_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data),
        .ready   (tbl_ready)
    );

    assign sh_eff   = (32'(block_shift_reg) > MAX_SHIFT) ? CFG_W'(MAX_SHIFT) : block_shift_reg;
    assign cap_full = ALU_W'(MAX_BLOCKS) << sh_eff;
    assign cap      = (cap_full > ALU_W'(COUNT_MAX)) ? ALU_W'(COUNT_MAX) : cap_full;
    assign off_mask = ~({OFF_W{1'b1}} << sh_eff);

    always_comb
    begin
        if (slots_reg == '0)
        begin
            slots_eff = (SLOT_W+1)'(1);
        end
        else if (32'(slots_reg) > SLOTS)
        begin
            slots_eff = (SLOT_W+1)'(SLOTS);
        end
        else
        begin
            slots_eff = (SLOT_W+1)'(slots_reg);
        end
    end

    assign look_victim = ({1'b0, ptr_reg} < slots_eff) ? ptr_reg : '0;
    assign fill_ptr    = (({1'b0, victim_reg} + 1'b1) >= slots_eff) ? '0 : victim_reg + 1'b1;
    assign busy        = (state_reg != S_IDLE) || !tbl_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        blk_next      = blk_reg;
        off_next      = off_reg;
        victim_next   = victim_reg;
        ptr_next      = ptr_reg;
        owner_we      = 1'b0;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        offset_next   = offset_reg;
        hit_next      = hit_reg;
        wb_valid_next = wb_valid_reg;
        wb_block_next = wb_block_reg;
        fetch_next    = fetch_reg;
        fresh_next    = fresh_reg;
        load_next     = load_reg;
        st_write_next = st_write_reg;
        st_value_next = st_value_reg;
        status_next   = status_reg;
        alu_op        = ALU_GE;
        alu_a         = '0;
        alu_b         = '0;
        tbl_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && tbl_ready)
                begin
                    cmd_next      = cmd;
                    idx_next      = CNT_W'(element_index);
                    val_next      = write_value;
                    slot_next     = '0;
                    offset_next   = '0;
                    hit_next      = 1'b0;
                    wb_valid_next = 1'b0;
                    wb_block_next = '0;
                    fetch_next    = 1'b0;
                    fresh_next    = 1'b0;
                    load_next     = '0;
                    st_write_next = 1'b0;
                    st_value_next = '0;
                    status_next   = ST_OK;
                    state_next    = S_RANGE;
                end
            end
            S_RANGE:
            begin
                alu_op = ALU_GE;
                alu_a  = cmd_reg ? ALU_W'(count_reg) : ALU_W'(idx_reg);
                alu_b  = cmd_reg ? cap : ALU_W'(count_reg);
                if (alu_res[0])
                begin
                    status_next = cmd_reg ? ST_FULL : ST_RANGE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (cmd_reg)
                    begin
                        idx_next   = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                alu_op     = ALU_SHR;
                alu_a      = ALU_W'(idx_reg);
                blk_next   = CNT_W'(alu_res);
                off_next   = idx_reg[OFF_W-1:0] & off_mask;
                state_next = S_BOUND;
            end
            S_BOUND:
            begin
                alu_op = ALU_GE;
                alu_a  = ALU_W'(blk_reg);
                alu_b  = ALU_W'(MAX_BLOCKS);
                if (alu_res[0])
                begin
                    status_next = ST_RANGE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.addr  = blk_reg[BLK_W-1:0];
                    state_next    = S_LOOK;
                end
            end
            S_LOOK:
            begin
                offset_next   = off_reg;
                st_write_next = cmd_reg;
                st_value_next = cmd_reg ? val_reg : '0;
                if (!tbl_rd_data[LOC_W-1])
                begin
                    hit_next   = 1'b1;
                    slot_next  = tbl_rd_data[SLOT_W-1:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    victim_next = look_victim;
                    slot_next   = look_victim;
                    if (owner_valid_reg[look_victim])
                    begin
                        tbl_req.wr_en   = 1'b1;
                        tbl_req.addr    = owner_reg[look_victim];
                        tbl_req.wr_data = LOC_STORED;
                        wb_valid_next   = 1'b1;
                        wb_block_next   = owner_reg[look_victim];
                    end
                    fetch_next = (tbl_rd_data == LOC_STORED);
                    fresh_next = (tbl_rd_data != LOC_STORED);
                    load_next  = blk_reg[BLK_W-1:0];
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.addr    = blk_reg[BLK_W-1:0];
                tbl_req.wr_data = LOC_W'(victim_reg);
                owner_we        = 1'b1;
                ptr_next        = fill_ptr;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            block_shift_reg <= CFG_W'(10);
            slots_reg       <= CFG_W'(16);
            count_reg       <= '0;
            ptr_reg         <= '0;
            done_reg        <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i]       <= (i < MAX_BLOCKS) ? BLK_W'(i) : '0;
                owner_valid_reg[i] <= (i < MAX_BLOCKS);
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_BLOCK_SHIFT:  block_shift_reg <= cfg_data;
                    REG_SLOTS_IN_USE: slots_reg       <= cfg_data;
                    default:          ;
                endcase
            end
            if (owner_we)
            begin
                owner_reg[victim_reg]       <= blk_reg[BLK_W-1:0];
                owner_valid_reg[victim_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        blk_reg      <= blk_next;
        off_reg      <= off_next;
        victim_reg   <= victim_next;
        slot_reg     <= slot_next;
        offset_reg   <= offset_next;
        hit_reg      <= hit_next;
        wb_valid_reg <= wb_valid_next;
        wb_block_reg <= wb_block_next;
        fetch_reg    <= fetch_next;
        fresh_reg    <= fresh_next;
        load_reg     <= load_next;
        st_write_reg <= st_write_next;
        st_value_reg <= st_value_next;
        status_reg   <= status_next;
    end

    assign done            = done_reg;
    assign slot_number     = slot_reg;
    assign slot_offset     = offset_reg;
    assign hit             = hit_reg;
    assign writeback_valid = wb_valid_reg;
    assign writeback_block = wb_block_reg;
    assign fetch_valid     = fetch_reg;
    assign fresh_block     = fresh_reg;
    assign load_block      = load_reg;
    assign store_write     = st_write_reg;
    assign store_value     = st_value_reg;
    assign status          = status_reg;

    a_hit_no_traffic: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !writeback_valid && !fetch_valid && !fresh_block)
        else $error("hit with backing store traffic");

    a_miss_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg == ST_OK) && !hit |-> fetch_valid != fresh_block)
        else $error("miss without exactly one of fetch or fresh");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg != ST_OK) |-> !hit && !store_write && !writeback_valid)
        else $error("error word carries side effects");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < SLOTS)
        else $error("victim pointer out of range");

endmodule

`default_nettype wire
